### rtl/aes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES package
// S-box table, GF(2^8) helpers and register indexes shared by the AES block.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int NumRkWords = 60;
	localparam int RkAw       = 6;

	typedef logic [RkAw-1:0] rk_addr_t;
	typedef logic [127:0]    block_t;

	typedef enum logic [2:0] {
		REG_KEY_SIZE = 3'd0,
		REG_KEY_0    = 3'd1,
		REG_KEY_1    = 3'd2,
		REG_KEY_2    = 3'd3,
		REG_KEY_3    = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		KS_128 = 2'd0,
		KS_192 = 2'd1,
		KS_256 = 2'd2
	} key_size_t;

	localparam logic [2047:0] SBOX = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		sbox = SBOX[2047 - 8*b -: 8];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] b);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 256; i++) begin
			if (SBOX[2047 - 8*i -: 8] == b) r = 8'(i);
		end
		inv_sbox = r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

endpackage

### rtl/aes_word_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES word channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface aes_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [63:0] block_high;
	logic [63:0] block_low;
	modport source (output valid, mode, block_high, block_low, input ready);
	modport sink   (input valid, mode, block_high, block_low, output ready);
endinterface

interface aes_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	modport source (output valid, result_high, result_low, input ready);
	modport sink   (input valid, result_high, result_low, output ready);
endinterface

### rtl/aes_rk_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round-key memory
// 60 x 32 store, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module aes_rk_mem (
	input  logic                clk,
	input  logic                we,
	input  aes_pkg::rk_addr_t   waddr,
	input  logic [31:0]         wdata,
	input  aes_pkg::rk_addr_t   raddr,
	output logic [31:0]         rdata
);
	import aes_pkg::*;

	logic [31:0] mem [NumRkWords];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### rtl/aes_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round logic
// One encrypt or decrypt round on a 128-bit state, including the key addition.
// ----------------------------------------------------------------------------
module aes_round (
	input  logic            decrypt,
	input  logic            last,
	input  aes_pkg::block_t key,
	input  aes_pkg::block_t din,
	output aes_pkg::block_t dout
);
	import aes_pkg::*;

	logic [7:0] s [16];
	logic [7:0] k [16];
	logic [7:0] t [16];
	logic [7:0] u [16];
	logic [7:0] m [16];

	function automatic logic [7:0] mul(input logic [7:0] a, input logic [3:0] c);
		logic [7:0] a2, a4, a8;
		a2 = xtime(a);
		a4 = xtime(a2);
		a8 = xtime(a4);
		mul = (c[0] ? a : 8'h00) ^ (c[1] ? a2 : 8'h00) ^ (c[2] ? a4 : 8'h00)
			^ (c[3] ? a8 : 8'h00);
	endfunction

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = din[127 - 8*i -: 8];
			k[i] = key[127 - 8*i -: 8];
		end
		// shift rows then byte substitution (order does not matter)
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (decrypt) t[r + 4*c] = inv_sbox(s[r + 4*((c + 4 - r) % 4)]);
				else         t[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
			end
		end
		// decrypt adds the round key before the inverse column mix
		for (int i = 0; i < 16; i++) u[i] = decrypt ? t[i] ^ k[i] : t[i];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (decrypt)
					m[4*c + r] = mul(u[4*c + r], 4'he) ^ mul(u[4*c + (r+1)%4], 4'hb)
						^ mul(u[4*c + (r+2)%4], 4'hd) ^ mul(u[4*c + (r+3)%4], 4'h9);
				else
					m[4*c + r] = mul(u[4*c + r], 4'h2) ^ mul(u[4*c + (r+1)%4], 4'h3)
						^ u[4*c + (r+2)%4] ^ u[4*c + (r+3)%4];
			end
		end
		for (int i = 0; i < 16; i++)
			dout[127 - 8*i -: 8] = (last ? u[i] : m[i]) ^ (decrypt ? 8'h00 : k[i]);
	end

endmodule

### rtl/aes_block_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block cipher unit
// ECB encrypt/decrypt of one 128-bit word with a 128/192/256-bit key.
// ----------------------------------------------------------------------------
// Configuration: write key_size and the key registers through cfg_we /
// cfg_index / cfg_data while nothing is in flight. Any write to these
// registers marks the key stale; the next input word first triggers key
// expansion, one schedule word per cycle into the round-key memory (44,
// 52 or 60 words in total, key load included).
// Data: in_ch carries mode and the block, out_ch returns the result.
// Each key addition needs four round-key words from the single memory read
// port, read one after another through the registered read data, and there
// are Nr+1 key additions. One word is in flight and in_ch.ready is high
// only while idle.
// A finished block moves to the output register once that is free, so a
// stalled receiver holds the result and blocks only the next block from
// finishing. After reset the key is all zero and key_size selects 128
// bits; the round-key memory is not cleared, it is always filled first.
// ----------------------------------------------------------------------------
module aes_block_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	aes_in_if.sink      in_ch,
	aes_out_if.source   out_ch
);
	import aes_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_KLOAD, ST_KEXP, ST_ROUND, ST_DONE} state_t;

	state_t      state_q;
	logic [1:0]  ksize_q;
	logic [63:0] key_q [4];
	logic        keys_ready_q;
	logic        mode_q;
	block_t      st_q;
	logic [95:0] key_acc_q;
	logic [5:0]  idx_q;     // schedule word / key word counter
	logic [2:0]  ipos_q;    // schedule word position within nk
	logic [3:0]  rnd_q;
	logic [2:0]  col_q;
	logic [7:0]  rcon_q;
	logic [31:0] win_q [8]; // sliding window of last nk schedule words
	logic        out_valid_q;
	block_t      out_q;

	logic        we;
	rk_addr_t    waddr, raddr;
	logic [31:0] wdata, rdata;
	logic [3:0]  nk, nr;
	logic [5:0]  total;
	logic [2:0]  top_pos;
	block_t      rnd_out;
	block_t      rk_cur;
	logic [31:0] prev, t_w, new_w;
	logic [31:0] win_d [8];
	logic        first_rnd, last_rnd;
	logic        cfg_hit, slot_free;

	aes_rk_mem u_mem (.clk, .we, .waddr, .wdata, .raddr, .rdata);
	aes_round  u_round (.decrypt(mode_q), .last(last_rnd), .key(rk_cur), .din(st_q),
		.dout(rnd_out));

	always_comb begin
		case (ksize_q)
			KS_128:  nk = 4'd4;
			KS_192:  nk = 4'd6;
			default: nk = 4'd8;
		endcase
		nr      = nk + 4'd6;
		total   = {nr, 2'b00} + 6'd4;
		top_pos = 3'(nk - 4'd1);
		prev    = win_q[top_pos];
		if (ipos_q == 3'd0)
			t_w = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_q, 24'h0};
		else if (nk == 4'd8 && ipos_q == 3'd4)
			t_w = sub_word(prev);
		else
			t_w = prev;
		new_w = win_q[0] ^ t_w;
	end

	always_comb begin
		we    = (state_q == ST_KLOAD) || (state_q == ST_KEXP);
		waddr = idx_q;
		if (state_q == ST_KLOAD)
			wdata = idx_q[0] ? key_q[idx_q[2:1]][31:0] : key_q[idx_q[2:1]][63:32];
		else
			wdata = new_w;
		raddr = {rnd_q, col_q[1:0]};
		for (int i = 0; i < 7; i++) win_d[i] = win_q[i+1];
		win_d[7]       = win_q[7];
		win_d[top_pos] = wdata;
	end

	assign rk_cur    = {key_acc_q, rdata};
	assign first_rnd = mode_q ? (rnd_q == nr) : (rnd_q == 4'd0);
	assign last_rnd  = mode_q ? (rnd_q == 4'd0) : (rnd_q == nr);
	assign cfg_hit   = cfg_we && (cfg_index inside {REG_KEY_SIZE, REG_KEY_0, REG_KEY_1,
		REG_KEY_2, REG_KEY_3});
	assign slot_free = !out_valid_q || out_ch.ready;

	assign in_ch.ready        = state_q == ST_IDLE;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.result_high = out_q[127:64];
	assign out_ch.result_low  = out_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ksize_q      <= KS_128;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			for (int i = 0; i < 8; i++) win_q[i] <= '0;
			keys_ready_q <= 1'b0;
			mode_q       <= 1'b0;
			st_q         <= '0;
			key_acc_q    <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			idx_q        <= '0;
			ipos_q       <= '0;
			rnd_q        <= '0;
			col_q        <= '0;
			rcon_q       <= 8'h01;
		end else begin
			out_valid_q <= (state_q == ST_DONE && slot_free) || (out_valid_q && !out_ch.ready);
			if (cfg_hit)
				keys_ready_q <= 1'b0;
			else if (state_q == ST_KEXP && idx_q == total - 6'd1)
				keys_ready_q <= 1'b1;
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_SIZE: begin
						ksize_q <= (cfg_data[1:0] == 2'd3) ? KS_256 : cfg_data[1:0];
					end
					REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3: begin
						key_q[2'(cfg_index - 3'd1)] <= cfg_data;
					end
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						mode_q  <= in_ch.mode;
						st_q    <= {in_ch.block_high, in_ch.block_low};
						col_q   <= '0;
						rnd_q   <= in_ch.mode ? nr : 4'd0;
						idx_q   <= '0;
						ipos_q  <= '0;
						rcon_q  <= 8'h01;
						state_q <= keys_ready_q ? ST_ROUND : ST_KLOAD;
					end
				end
				ST_KLOAD: begin
					for (int i = 0; i < 8; i++) win_q[i] <= win_d[i];
					idx_q  <= idx_q + 6'd1;
					ipos_q <= (ipos_q == top_pos) ? 3'd0 : ipos_q + 3'd1;
					if (idx_q == {2'b00, nk} - 6'd1) state_q <= ST_KEXP;
				end
				ST_KEXP: begin
					for (int i = 0; i < 8; i++) win_q[i] <= win_d[i];
					if (ipos_q == 3'd0) rcon_q <= xtime(rcon_q);
					idx_q  <= idx_q + 6'd1;
					ipos_q <= (ipos_q == top_pos) ? 3'd0 : ipos_q + 3'd1;
					if (idx_q == total - 6'd1) state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					// col 0..3 issue reads, data arrives in the next cycle
					if (col_q != 3'd0) key_acc_q <= {key_acc_q[63:0], rdata};
					if (col_q == 3'd4) begin
						col_q <= '0;
						st_q  <= first_rnd ? st_q ^ rk_cur : rnd_out;
						if (last_rnd)
							state_q <= ST_DONE;
						else if (mode_q)
							rnd_q <= rnd_q - 4'd1;
						else
							rnd_q <= rnd_q + 4'd1;
					end else begin
						col_q <= col_q + 3'd1;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						out_q   <= st_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
